>>> sv/btc_pkg.sv
// Shared types, constants and key helpers for the block transposition cipher.
// No dependencies; every other file in sv/ refers to this package by scoped names.
package btc_pkg;

    localparam int MAX_BLOCK_DEF = 16;   // default block store depth
    localparam int KEY_ENTRIES   = 16;   // nibbles held in key_map
    localparam int NIB_W         = 4;
    localparam int BSIZE_W       = 5;
    localparam int KEY_W         = 64;
    localparam int BYTE_W        = 8;
    localparam int ERR_W         = 2;
    localparam int REG_IDX_W     = 2;

    // Register indexes on the config port
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_MAP    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIRECTION  = 2'd2;

    // Reset values
    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = 5'd16;
    localparam logic [KEY_W-1:0]   KEY_MAP_RST    = 64'hFEDC_BA98_7654_3210;
    localparam logic               DIRECTION_RST  = 1'b0;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_KEY   = 2'd1,
        ERR_TRUNC = 2'd2
    } t_err;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Nibble idx of the key
    function automatic logic [NIB_W-1:0] key_entry(input logic [KEY_W-1:0] key,
                                                   input logic [NIB_W-1:0] idx);
        logic [KEY_W-1:0] sh;
        sh = key >> {idx, 2'b00};
        return sh[NIB_W-1:0];
    endfunction

    // Key is usable when 2 <= n <= max_blk and entries 0..n-1 permute 0..n-1
    function automatic logic key_ok(input logic [BSIZE_W-1:0] n,
                                    input logic [KEY_W-1:0]   key,
                                    input int unsigned        max_blk);
        logic [KEY_ENTRIES-1:0] seen;
        logic [KEY_ENTRIES:0]   full;
        logic                   bad;
        logic [NIB_W-1:0]       e;
        seen = '0;
        bad  = 1'b0;
        for (int i = 0; i < KEY_ENTRIES; i++) begin
            e = key[NIB_W*i +: NIB_W];
            if (BSIZE_W'(i) < n) begin
                if ({1'b0, e} >= n) begin
                    bad = 1'b1;
                end
                seen = seen | (KEY_ENTRIES'(1) << e);
            end
        end
        full = ((KEY_ENTRIES+1)'(1) << n) - (KEY_ENTRIES+1)'(1);
        return !bad && (n >= BSIZE_W'(2)) && (32'(n) <= max_blk)
               && (seen == full[KEY_ENTRIES-1:0]);
    endfunction

endpackage

>>> sv/btc_cfg_if.sv
// Configuration write channel: register index and write data with valid/ready.
// Depends on btc_pkg for widths.
interface btc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [btc_pkg::REG_IDX_W-1:0]   reg_index;
    logic [btc_pkg::KEY_W-1:0]       wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

>>> sv/btc_in_if.sv
// Input byte channel: data byte and end-of-stream flag with valid/ready.
// Depends on btc_pkg for widths.
interface btc_in_if;
    logic                          valid;
    logic                          ready;
    logic [btc_pkg::BYTE_W-1:0]    data_byte;
    logic                          end_of_stream;

    modport source (output valid, data_byte, end_of_stream, input ready);
    modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

>>> sv/btc_out_if.sv
// Result channel: permuted byte, block end flag and error code with valid/ready.
// Depends on btc_pkg for widths.
interface btc_out_if;
    logic                          valid;
    logic                          ready;
    logic [btc_pkg::BYTE_W-1:0]    out_byte;
    logic                          block_end;
    logic [btc_pkg::ERR_W-1:0]     error_code;

    modport source (output valid, out_byte, block_end, error_code, input ready);
    modport sink   (input valid, out_byte, block_end, error_code, output ready);
endinterface

>>> sv/block_transposition_cipher_top.sv
// Block transposition cipher top level: block store memory, emit sequencer, output stage.
// Depends on btc_pkg, btc_cfg_if, btc_in_if and btc_out_if.
//
// Usage:
//   i_cfg  : register writes (0 block_size, 1 key_map, 2 direction); always ready.
//            Write only while the block is idle; other indexes are ignored.
//   i_in   : one byte per transaction; end_of_stream closes the text.
//   o_out  : one transaction per emitted byte, or a single error transaction.
// Bytes land in a single-port-write / single-port-read block store, one per
// cycle while the sequencer is idle and the read stage has room. The byte that
// fills a block (or ends the text) switches the sequencer to emit: it walks the
// n output positions, one memory read per cycle while the read stage has room,
// and holds off new input meanwhile. The closing transaction moves the sequencer
// to emit; each read, like an error result, goes through the read stage into the
// output register. The emit rate is set by the one read port of the block store.
// Reset (synchronous, i_rst_n low) restores the config defaults (block 16,
// identity key, encrypt), empties the block and the pipeline; store contents
// are left as they are. A stalled receiver holds the output register; the
// read stage behind it holds too, and input is refused once that stage is full.
module block_transposition_cipher_top #(
    parameter int MAX_BLOCK = btc_pkg::MAX_BLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    btc_cfg_if.sink     i_cfg,
    btc_in_if.sink      i_in,
    btc_out_if.source   o_out
);

    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;   // store address
    localparam int CW = $clog2(MAX_BLOCK + 1);                      // fill count

    // Config registers
    logic [btc_pkg::BSIZE_W-1:0] r_block_size;
    logic [btc_pkg::KEY_W-1:0]   r_key_map;
    logic                        r_direction;

    // Sequencer
    btc_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_fill;
    logic [CW-1:0]   r_emit_fill;   // bytes held by the block being emitted
    logic [AW-1:0]   r_idx;         // output position during emit

    // Block store
    logic [btc_pkg::BYTE_W-1:0] r_mem [MAX_BLOCK];
    logic [btc_pkg::BYTE_W-1:0] r_rd_byte;

    // Read stage (lines up with memory read data)
    logic            r_s1_valid;
    logic            r_s1_zero;
    logic            r_s1_end;
    btc_pkg::t_err   r_s1_err;

    // Output register
    logic                       r_out_valid;
    logic [btc_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_out_end;
    btc_pkg::t_err              r_out_err;

    logic                       key_good;
    logic                       s2_load;
    logic                       s1_free;
    logic                       in_ready;
    logic                       issue;
    logic                       in_acc;
    logic [CW-1:0]              fill_inc;
    logic                       short_blk;
    logic                       blk_done;
    logic                       emit_start;
    logic                       err_new;
    btc_pkg::t_err              err_code;
    logic                       wr_en;
    logic [btc_pkg::NIB_W-1:0]  enc_entry;
    logic [btc_pkg::NIB_W-1:0]  dec_src;
    logic [AW-1:0]              rd_addr;
    logic                       rd_zero;
    logic                       last_idx;

    // ---------------- config port ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= btc_pkg::BLOCK_SIZE_RST;
            r_key_map    <= btc_pkg::KEY_MAP_RST;
            r_direction  <= btc_pkg::DIRECTION_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                btc_pkg::REG_BLOCK_SIZE: r_block_size <= i_cfg.wr_data[btc_pkg::BSIZE_W-1:0];
                btc_pkg::REG_KEY_MAP:    r_key_map    <= i_cfg.wr_data;
                btc_pkg::REG_DIRECTION:  r_direction  <= i_cfg.wr_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- datapath decode ----------------
    assign key_good = btc_pkg::key_ok(r_block_size, r_key_map, MAX_BLOCK);

    // pipeline flow: output reg frees, read stage frees behind it
    assign s2_load = !r_out_valid || o_out.ready;
    assign s1_free = !r_s1_valid || s2_load;

    assign in_acc = i_in.valid && in_ready;

    // saturating fill count after storing this byte
    assign fill_inc  = (r_fill == CW'(MAX_BLOCK)) ? r_fill : r_fill + 1'b1;
    assign short_blk = 6'(fill_inc) < 6'(r_block_size);
    assign blk_done  = !short_blk || i_in.end_of_stream;

    assign emit_start = in_acc && key_good && blk_done && !(short_blk && r_direction);
    assign err_new    = in_acc && (!key_good || (blk_done && short_blk && r_direction));
    assign err_code   = key_good ? btc_pkg::ERR_TRUNC : btc_pkg::ERR_KEY;

    // store only while there is room; overflow bytes past MAX_BLOCK are dropped
    assign wr_en = in_acc && key_good && (r_fill < CW'(MAX_BLOCK));

    // encrypt: position i takes block[key i]
    assign enc_entry = btc_pkg::key_entry(r_key_map, btc_pkg::NIB_W'(r_idx));

    // decrypt: position j takes block[i] where key i == j
    always_comb begin
        dec_src = '0;
        for (int i = 0; i < btc_pkg::KEY_ENTRIES; i++) begin
            if (btc_pkg::BSIZE_W'(i) < r_block_size &&
                r_key_map[btc_pkg::NIB_W*i +: btc_pkg::NIB_W] == btc_pkg::NIB_W'(r_idx)) begin
                dec_src = btc_pkg::NIB_W'(i);
            end
        end
    end

    assign rd_addr  = r_direction ? dec_src[AW-1:0] : enc_entry[AW-1:0];
    // zero padding for positions beyond the fill (encrypt only)
    assign rd_zero  = !r_direction && (5'(enc_entry) >= 5'(r_emit_fill));
    assign last_idx = (5'(r_idx) + 5'd1) == r_block_size;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            btc_pkg::ST_IDLE: begin
                if (emit_start) begin
                    n_state = btc_pkg::ST_EMIT;
                end
            end
            btc_pkg::ST_EMIT: begin
                if (issue && last_idx) begin
                    n_state = btc_pkg::ST_IDLE;
                end
            end
            default: n_state = btc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        case (r_state)
            btc_pkg::ST_IDLE: in_ready = s1_free;
            btc_pkg::ST_EMIT: issue    = s1_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btc_pkg::ST_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                if (!key_good || blk_done) begin
                    r_fill <= '0;
                end else begin
                    r_fill <= fill_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_start) begin
            r_emit_fill <= fill_inc;
            r_idx       <= '0;
        end else if (issue) begin
            r_idx       <= r_idx + 1'b1;
        end
    end

    // ---------------- block store ----------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill[AW-1:0]] <= i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_byte <= r_mem[rd_addr];
        end
    end

    // ---------------- read stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (issue || err_new) begin
            r_s1_valid <= 1'b1;
        end else if (s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_zero <= rd_zero;
            r_s1_end  <= last_idx;
            r_s1_err  <= btc_pkg::ERR_NONE;
        end else if (err_new) begin
            r_s1_zero <= 1'b1;
            r_s1_end  <= 1'b1;
            r_s1_err  <= err_code;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r_s1_valid) begin
            r_out_byte <= r_s1_zero ? '0 : r_rd_byte;
            r_out_end  <= r_s1_end;
            r_out_err  <= r_s1_err;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.block_end  = r_out_end;
    assign o_out.error_code = r_out_err;

endmodule

>>> tb/sv/btc_cipher_checker.sv
// Checker for the block transposition cipher: watches the config, input and result
// channels, predicts each permuted block and compares results in order.
// Depends on btc_pkg for widths, register indexes and error codes.
module btc_cipher_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [btc_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [btc_pkg::KEY_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [btc_pkg::BYTE_W-1:0]    i_in_byte,
    input  logic                          i_in_eos,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [btc_pkg::BYTE_W-1:0]    i_out_byte,
    input  logic                          i_out_end,
    input  logic [btc_pkg::ERR_W-1:0]     i_out_err,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [btc_pkg::BYTE_W-1:0] cipher_byte;
        logic                       blk_end;
        btc_pkg::t_err              code;
    } t_cipher_result;

    t_cipher_result     pending_results[$];

    // Shadow copy of the block's registers and block buffer
    logic [btc_pkg::BSIZE_W-1:0] blk_size;
    logic [btc_pkg::KEY_W-1:0]   key_nibbles;
    logic                        decrypt;
    logic [btc_pkg::BYTE_W-1:0]  held_bytes [btc_pkg::MAX_BLOCK_DEF];
    logic [btc_pkg::BSIZE_W-1:0] held_count;

    function automatic logic [btc_pkg::NIB_W-1:0] nib(input int i);
        return key_nibbles[btc_pkg::NIB_W*i +: btc_pkg::NIB_W];
    endfunction

    function automatic logic key_is_perm();
        logic [btc_pkg::MAX_BLOCK_DEF-1:0] hit;
        int n;
        int i;
        n = int'(blk_size);
        if (n < 2 || n > btc_pkg::MAX_BLOCK_DEF) begin
            return 1'b0;
        end
        hit = '0;
        for (i = 0; i < n; i++) begin
            if (int'(nib(i)) >= n) begin
                return 1'b0;
            end
            hit[nib(i)] = 1'b1;
        end
        return hit == btc_pkg::MAX_BLOCK_DEF'((32'd1 << n) - 32'd1);
    endfunction

    function automatic void push_result(input logic [btc_pkg::BYTE_W-1:0] b, input logic e,
                                        input btc_pkg::t_err c);
        t_cipher_result r;
        r.cipher_byte = b;
        r.blk_end     = e;
        r.code        = c;
        pending_results.push_back(r);
    endfunction

    // One accepted byte: store it, and emit the permuted block when it closes one
    function automatic void absorb_byte(input logic [btc_pkg::BYTE_W-1:0] b, input logic eos);
        logic [btc_pkg::BYTE_W-1:0] blk  [btc_pkg::MAX_BLOCK_DEF];
        logic [btc_pkg::BYTE_W-1:0] perm [btc_pkg::MAX_BLOCK_DEF];
        int n;
        int fill;
        int i;
        if (!key_is_perm()) begin
            held_count = '0;
            push_result('0, 1'b1, btc_pkg::ERR_KEY);
            return;
        end
        n = int'(blk_size);
        if (int'(held_count) < btc_pkg::MAX_BLOCK_DEF) begin
            held_bytes[held_count] = b;
        end
        fill = int'(held_count) + 1;
        if (fill > btc_pkg::MAX_BLOCK_DEF) begin
            fill = btc_pkg::MAX_BLOCK_DEF;
        end
        held_count = btc_pkg::BSIZE_W'(fill);
        if (fill < n && !eos) begin
            return;
        end
        held_count = '0;
        if (fill < n && decrypt) begin
            push_result('0, 1'b1, btc_pkg::ERR_TRUNC);
            return;
        end
        // short final block in encrypt mode gets zero padding
        for (i = 0; i < n; i++) begin
            blk[i] = (i < fill) ? held_bytes[i] : 8'h00;
        end
        for (i = 0; i < n; i++) begin
            if (!decrypt) begin
                perm[i] = blk[nib(i)];
            end else begin
                perm[nib(i)] = blk[i];
            end
        end
        for (i = 0; i < n; i++) begin
            push_result(perm[i], i == n - 1, btc_pkg::ERR_NONE);
        end
    endfunction

    function automatic void note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    always @(posedge i_clk) begin
        t_cipher_result want;
        if (!i_rst_n) begin
            blk_size    = btc_pkg::BLOCK_SIZE_RST;
            key_nibbles = btc_pkg::KEY_MAP_RST;
            decrypt     = btc_pkg::DIRECTION_RST;
            held_count  = '0;
            foreach (held_bytes[k]) held_bytes[k] = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    btc_pkg::REG_BLOCK_SIZE: blk_size    = i_cfg_data[btc_pkg::BSIZE_W-1:0];
                    btc_pkg::REG_KEY_MAP:    key_nibbles = i_cfg_data;
                    btc_pkg::REG_DIRECTION:  decrypt     = i_cfg_data[0];
                    default: ;
                endcase
            end
            // results of earlier transactions are compared before new ones are queued
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result byte %02h end %0b code %0d",
                                           i_out_byte, i_out_end, i_out_err));
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_byte !== want.cipher_byte || i_out_end !== want.blk_end
                        || i_out_err !== want.code) begin
                        note_failure($sformatf(
                            "mismatch: expected byte %02h end %0b code %0d, got %02h %0b %0d",
                            want.cipher_byte, want.blk_end, want.code,
                            i_out_byte, i_out_end, i_out_err));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                absorb_byte(i_in_byte, i_in_eos);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

>>> tb/sv/tb_block_transposition_cipher_top.sv
// Testbench top for block_transposition_cipher_top: clock, reset, stimulus and verdict.
// Depends on btc_pkg, the three channel interfaces, the DUT and btc_cipher_checker.
module tb_block_transposition_cipher_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [btc_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;  // index the block ignores
    localparam int ITEMS_PER_STAGE = 62;     // random input bytes per idling stage
    localparam int DRAIN_CYCLES    = 24;     // quiet cycles after the last result
    localparam int HOLD_CYCLES     = 64;     // long receiver hold-off
    localparam int WATCHDOG_LIMIT  = 2000;   // cycles with no transaction at all

    logic i_clk;
    logic i_rst_n;

    btc_cfg_if cfg_ch ();
    btc_in_if  in_ch ();
    btc_out_if out_ch ();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_seq;
    int stage_items;
    int fail_count;
    int pending;

    block_transposition_cipher_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    btc_cipher_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_index  (cfg_ch.reg_index),
        .i_cfg_data   (cfg_ch.wr_data),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_byte    (in_ch.data_byte),
        .i_in_eos     (in_ch.end_of_stream),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_byte   (out_ch.out_byte),
        .i_out_end    (out_ch.block_end),
        .i_out_err    (out_ch.error_code),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, plus a long hold-off on request. The hold
    // is counted here so the sender keeps offering bytes until the block's
    // read stage and output register are full and it refuses input.
    initial begin : receiver
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != seen_seq) begin
                seen_seq  = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: a run that stops moving transactions ends as a failure.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    // One byte transaction. Leaves valid high on return; the caller lowers it
    // before a pause so that valid never drops and rises in the same step.
    task automatic send_byte(input logic [btc_pkg::BYTE_W-1:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_stream <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // A text of random bytes; close marks its last byte as end of stream.
    task automatic run_text(input int len, input bit close);
        int k;
        for (k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(255)), close && (k == len - 1));
            stage_items++;
        end
    endtask

    // Waits until nothing is pending and the block has had time to finish a
    // byte that leaves a block open. Sampled at the falling edge to stay clear
    // of the checker's update at the rising one.
    task automatic wait_drained();
        int quiet;
        quiet = 0;
        while (quiet < DRAIN_CYCLES) begin
            @(negedge i_clk);
            if (pending == 0) begin
                quiet++;
            end else begin
                quiet = 0;
            end
        end
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [btc_pkg::REG_IDX_W-1:0] idx,
                             input logic [btc_pkg::KEY_W-1:0] val);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Full register update, only once the block is idle. Unused upper bits of
    // the size and direction words carry random data, which the block drops.
    task automatic set_config(input int bs, input logic [btc_pkg::KEY_W-1:0] key,
                              input logic dir);
        logic [btc_pkg::KEY_W-1:0] word;
        in_ch.valid <= 1'b0;
        wait_drained();
        write_reg(REG_UNUSED, {$urandom, $urandom});
        word = {$urandom, $urandom};
        word[btc_pkg::BSIZE_W-1:0] = btc_pkg::BSIZE_W'(bs);
        write_reg(btc_pkg::REG_BLOCK_SIZE, word);
        write_reg(btc_pkg::REG_KEY_MAP, key);
        word = {$urandom, $urandom};
        word[0] = dir;
        write_reg(btc_pkg::REG_DIRECTION, word);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random permutation of 0..n-1 in the low nibbles, random filler above
    function automatic logic [btc_pkg::KEY_W-1:0] shuffled_key(input int n);
        logic [btc_pkg::KEY_W-1:0] k;
        logic [btc_pkg::NIB_W-1:0] tmp;
        int i;
        int j;
        k = {$urandom, $urandom};
        for (i = 0; i < n; i++) begin
            k[btc_pkg::NIB_W*i +: btc_pkg::NIB_W] = btc_pkg::NIB_W'(i);
        end
        for (i = n - 1; i > 0; i--) begin
            j   = $urandom_range(i);
            tmp = k[btc_pkg::NIB_W*i +: btc_pkg::NIB_W];
            k[btc_pkg::NIB_W*i +: btc_pkg::NIB_W] = k[btc_pkg::NIB_W*j +: btc_pkg::NIB_W];
            k[btc_pkg::NIB_W*j +: btc_pkg::NIB_W] = tmp;
        end
        return k;
    endfunction

    initial begin : stimulus
        int stage;
        int n;
        int r;
        int len;
        logic [btc_pkg::KEY_W-1:0] key;

        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= '0;
        in_ch.end_of_stream  <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.reg_index     <= btc_pkg::REG_BLOCK_SIZE;
        cfg_ch.wr_data       <= '0;
        hold_seq      = 0;
        stage_items   = 0;
        send_idle_pct = 9;
        recv_idle_pct = 46;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the first idling profile.
        // Reset settings: one byte closing the text pads to a full 16-byte block.
        send_byte(8'hA5, 1'b1);

        // Smallest block, swapped key, encrypt; byte extremes.
        set_config(2, 64'hFFFF_FFFF_FFFF_FF01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Decrypt: a full block, then a short closing block is truncated.
        set_config(3, 64'h0000_0000_0000_0102, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b1);

        // Encrypt with a reversed key: short final block gets zero padding.
        set_config(4, 64'h0000_0000_0000_0123, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b1);

        // Invalid keys: size below two, size above the maximum, repeated entries,
        // and all-ones at full size. Each byte gives a single key error.
        set_config(1, btc_pkg::KEY_MAP_RST, 1'b0);
        send_byte(8'h01, 1'b0);
        set_config(31, btc_pkg::KEY_MAP_RST, 1'b1);
        send_byte(8'h80, 1'b1);
        set_config(4, 64'h0, 1'b0);
        send_byte(8'h7F, 1'b0);
        set_config(16, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_byte(8'hFE, 1'b0);

        // Block size lowered mid-block: five bytes held at size 16, then size 3;
        // the next byte closes a block made of the first three.
        set_config(16, btc_pkg::KEY_MAP_RST, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h50, 1'b0);
        set_config(3, btc_pkg::KEY_MAP_RST, 1'b1);
        send_byte(8'h60, 1'b0);

        // Decrypt where end of stream lands exactly on a full block.
        set_config(2, 64'h0000_0000_0000_0001, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);

        // Random part: three idling profiles, each opening with a long
        // receiver hold-off while a long text keeps the input busy.
        for (stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 46;
                end
                1: begin
                    send_idle_pct = 46;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            stage_items = 0;
            set_config(4, shuffled_key(4), 1'($urandom_range(1)));
            hold_seq++;
            run_text(24, 1'b1);

            while (stage_items < ITEMS_PER_STAGE) begin
                if ($urandom_range(99) < 85) begin
                    // well-formed: valid key, mostly small blocks, some full size
                    r = $urandom_range(99);
                    if (r < 12) begin
                        n = 16;
                    end else if (r < 20) begin
                        n = $urandom_range(15, 7);
                    end else begin
                        n = $urandom_range(6, 2);
                    end
                    set_config(n, shuffled_key(n), 1'($urandom_range(1)));
                    len = $urandom_range(3 * n, 1);
                end else begin
                    // broken key: bad size, or entries 0 and 1 equal
                    key = {$urandom, $urandom};
                    if ($urandom_range(1) == 1) begin
                        n = ($urandom_range(1) == 1) ? $urandom_range(1) : $urandom_range(31, 17);
                    end else begin
                        n = $urandom_range(16, 2);
                        key[2*btc_pkg::NIB_W-1:btc_pkg::NIB_W] = key[btc_pkg::NIB_W-1:0];
                    end
                    set_config(n, key, 1'($urandom_range(1)));
                    len = $urandom_range(4, 1);
                end
                // an unclosed text leaves bytes held across the next config
                run_text(len, $urandom_range(99) < 85);
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/btc_pkg.sv
sv/btc_cfg_if.sv
sv/btc_in_if.sv
sv/btc_out_if.sv
sv/block_transposition_cipher_top.sv
tb/sv/btc_cipher_checker.sv
tb/sv/tb_block_transposition_cipher_top.sv
